### sv/sphere_triangle_closest_point_macros.svh
// Assertion macros used by the sphere-triangle closest point top level.
`ifndef SPHERE_TRIANGLE_CLOSEST_POINT_MACROS_SVH
`define SPHERE_TRIANGLE_CLOSEST_POINT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stcp_pkg.sv
// Shared constants, types and helpers of the sphere-triangle closest point block.
package stcp_pkg;

  localparam int CW    = 16;          // coordinate width
  localparam int DFW   = CW + 1;      // coordinate difference width
  localparam int PRW   = 2 * DFW;     // product of two differences
  localparam int DW    = PRW + 2;     // dot product of two difference vectors
  localparam int HW    = DW / 2;      // half of a dot product, for split multiplies
  localparam int MW    = 2 * DW;      // product of two dot products
  localparam int VW    = MW + 2;      // barycentric terms and their sum
  localparam int TB    = 16;          // fraction bits of an edge or barycentric weight
  localparam int RW    = CW - 1;      // radius width
  localparam int QD    = 4;           // queue depth
  localparam int QAW   = 2;           // queue pointer width
  localparam int IN_W  = 9 * CW;
  localparam int OUT_BITS = 1 + 3 * CW + 3;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_RG_LSB = 1 + 3 * CW;
  localparam int CFG_IW = 2;

  localparam logic [2:0] RG_V0  = 3'd0;
  localparam logic [2:0] RG_V1  = 3'd1;
  localparam logic [2:0] RG_E01 = 3'd2;
  localparam logic [2:0] RG_V2  = 3'd3;
  localparam logic [2:0] RG_E02 = 3'd4;
  localparam logic [2:0] RG_E12 = 3'd5;
  localparam logic [2:0] RG_IN  = 3'd6;

  localparam logic [CFG_IW-1:0] CFG_CX  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_CY  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CZ  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_RAD = 2'd3;

  typedef logic [2:0][CW-1:0]  pt_t;   // x in the low element
  typedef logic [2:0][DFW-1:0] dl_t;

  typedef struct packed {
    pt_t p0;
    pt_t p1;
    pt_t p2;
    dl_t e01;
    dl_t e02;
    dl_t e12;
  } geo_t;

  // One classified triangle, handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]          region;
    pt_t                 base;
    dl_t                 dir1;
    dl_t                 dir2;
    logic signed [VW-1:0] num1;
    logic signed [VW-1:0] num2;
    logic signed [VW-1:0] den;
  } qi_t;

  typedef struct packed {
    logic [2:0] region;
    pt_t        base;
    dl_t        dir1;
    dl_t        dir2;
  } pay_t;

  // Signed difference a - b of two coordinates, one bit wider.
  function automatic logic [DFW-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

endpackage

### sv/sphere_triangle_closest_point.sv
// Top level of the sphere versus triangle closest point stream engine.
//
// Usage: the sphere (center x, y, z and radius, Q8.8) is written through the
// cfg_ channel, register index 0..3 in that order; cfg_ready is always high.
// Write it only while no triangle is in flight. Triangles then stream in on
// the in_ channel, one request per accepted beat, and one result per triangle
// leaves on the out_ channel in the same order: hit flag, the closest point
// on the triangle and its Voronoi region code.
// Throughput is one triangle per cycle while the output is not stalled. The
// classifying front end computes edge vectors, dot products, split 36x36
// products and the region choice; a four-entry queue follows, and the back
// end holds the one-bit-per-stage fraction dividers, then interpolation and
// the hit test.
// Reset (rst_n low at a clock edge) empties the pipelines and the queue and
// clears the sphere registers to zero.
// When out_tready stays low the back end holds, the queue fills, and then
// the front end holds and drops in_tready; nothing is lost or repeated.
`include "sphere_triangle_closest_point_macros.svh"

module sphere_triangle_closest_point (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata, from bit 0 up: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [stcp_pkg::IN_W-1:0]      in_tdata,
  // out_tdata, from bit 0 up: hit, near_x, near_y, near_z, region, zero fill
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [stcp_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stcp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [stcp_pkg::CW-1:0]        cfg_data
);

  stcp_pkg::pt_t              cen_r;
  logic [stcp_pkg::RW-1:0]    rad_r;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  stcp_pkg::qi_t              q_wdata;
  stcp_pkg::qi_t              q_rdata;
  logic [2:0]                 out_rg;

  assign cfg_ready = 1'b1;
  assign out_rg    = out_tdata[stcp_pkg::OUT_RG_LSB +: 3];

  // Sphere registers. Indices past the radius do not exist in this map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r <= '0;
      rad_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stcp_pkg::CFG_CX:  cen_r[0] <= cfg_data;
        stcp_pkg::CFG_CY:  cen_r[1] <= cfg_data;
        stcp_pkg::CFG_CZ:  cen_r[2] <= cfg_data;
        stcp_pkg::CFG_RAD: rad_r    <= cfg_data[stcp_pkg::RW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classifies each triangle and computes the fraction terms.
  stcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .cen      (cen_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wdata)
  );

  // The queue lets the two halves stall independently.
  stcp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: divides, interpolates, and runs the hit test into the output register.
  stcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rdata),
    .q_pop     (q_pop),
    .cen       (cen_r),
    .rad       (rad_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  `STCP_ASSERT_NOW(a_q_flags, clk, rst_n, q_full, !q_empty, "queue reports full and empty")
  `STCP_ASSERT_NEXT(a_q_hold, clk, rst_n, q_full && !q_pop, q_full, "queue full flag fell without a read")
  `STCP_ASSERT_NOW(a_region, clk, rst_n, out_tvalid, out_rg <= stcp_pkg::RG_IN, "region code out of range")

endmodule

### sv/stcp_fifo.sv
// Small request queue between the classifying front end and the back end.
module stcp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stcp_pkg::qi_t  wdata,
  output logic           full,
  input  logic           pop,
  output stcp_pkg::qi_t  rdata,
  output logic           empty
);

  stcp_pkg::qi_t                mem_r [stcp_pkg::QD];
  logic [stcp_pkg::QAW-1:0]     wptr_r;
  logic [stcp_pkg::QAW-1:0]     rptr_r;
  logic [stcp_pkg::QAW:0]       cnt_r;

  assign full  = (cnt_r == (stcp_pkg::QAW + 1)'(stcp_pkg::QD));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### sv/stcp_front.sv
// Front end: edge vectors, dot products, barycentric terms and region classification.
module stcp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [stcp_pkg::IN_W-1:0]   in_data,
  input  stcp_pkg::pt_t               cen,
  input  logic                        q_full,
  output logic                        q_push,
  output stcp_pkg::qi_t               q_item
);

  localparam int DW  = stcp_pkg::DW;
  localparam int HW  = stcp_pkg::HW;
  localparam int MW  = stcp_pkg::MW;
  localparam int VW  = stcp_pkg::VW;
  localparam int PRW = stcp_pkg::PRW;
  localparam int CW  = stcp_pkg::CW;
  // Operand pairs of the six dot-product products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  logic                  en;
  logic [7:1]            vld_r;
  stcp_pkg::geo_t        geo_in;
  stcp_pkg::dl_t         a_in [3];
  stcp_pkg::geo_t        geo_r [1:6];
  stcp_pkg::dl_t         a_r [3];
  logic signed [PRW-1:0] pr_nxt [6][3];
  logic signed [PRW-1:0] pr_r [6][3];
  logic signed [DW-1:0]  d_nxt [6];
  logic signed [DW-1:0]  d_r [3:6][6];
  logic signed [2*HW-1:0] hh_nxt [6];
  logic signed [2*HW+1:0] mid_nxt [6];
  logic [2*HW-1:0]        ll_nxt [6];
  logic signed [2*HW-1:0] hh_r [6];
  logic signed [2*HW+1:0] mid_r [6];
  logic [2*HW-1:0]        ll_r [6];
  logic signed [MW-1:0]   pm_nxt [6];
  logic signed [MW-1:0]   pm_r [6];
  logic signed [VW-1:0]   va_r, vb_r, vc_r;
  logic signed [DW:0]     n_r, m_r;
  stcp_pkg::qi_t          item_nxt;
  stcp_pkg::qi_t          item_r;

  // The whole front pipeline moves together; it only holds when its last
  // stage is full and the queue has no room.
  assign en       = !vld_r[7] || !q_full;
  assign in_ready = en;
  assign q_push   = vld_r[7] && !q_full;
  assign q_item   = item_r;

  always_comb begin
    geo_in.p0 = in_data[3*CW-1:0];
    geo_in.p1 = in_data[6*CW-1:3*CW];
    geo_in.p2 = in_data[9*CW-1:6*CW];
    for (int k = 0; k < 3; k++) begin
      geo_in.e01[k] = stcp_pkg::dif(geo_in.p1[k], geo_in.p0[k]);
      geo_in.e02[k] = stcp_pkg::dif(geo_in.p2[k], geo_in.p0[k]);
      geo_in.e12[k] = stcp_pkg::dif(geo_in.p2[k], geo_in.p1[k]);
      a_in[0][k]    = stcp_pkg::dif(cen[k], geo_in.p0[k]);
      a_in[1][k]    = stcp_pkg::dif(cen[k], geo_in.p1[k]);
      a_in[2][k]    = stcp_pkg::dif(cen[k], geo_in.p2[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pr_nxt[2*i][k]   = $signed(geo_r[1].e01[k]) * $signed(a_r[i][k]);
        pr_nxt[2*i+1][k] = $signed(geo_r[1].e02[k]) * $signed(a_r[i][k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      d_nxt[j] = DW'(pr_r[j][0]) + DW'(pr_r[j][1]) + DW'(pr_r[j][2]);
    end
  end

  // Each 36 by 36 product is split into 18-bit halves: high by high,
  // the two cross terms, and low by low.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      hh_nxt[j]  = $signed(d_r[3][PA[j]][DW-1:HW]) * $signed(d_r[3][PB[j]][DW-1:HW]);
      mid_nxt[j] = (2*HW+2)'($signed(d_r[3][PA[j]][DW-1:HW])
                             * $signed({1'b0, d_r[3][PB[j]][HW-1:0]}))
                 + (2*HW+2)'($signed({1'b0, d_r[3][PA[j]][HW-1:0]})
                             * $signed(d_r[3][PB[j]][DW-1:HW]));
      ll_nxt[j]  = d_r[3][PA[j]][HW-1:0] * d_r[3][PB[j]][HW-1:0];
    end
  end

  always_comb begin
    logic signed [MW-1:0] hx;
    logic signed [MW-1:0] mx;
    logic signed [MW-1:0] lx;
    for (int j = 0; j < 6; j++) begin
      hx = MW'(hh_r[j]);
      mx = MW'(mid_r[j]);
      lx = {{(MW-2*HW){1'b0}}, ll_r[j]};
      pm_nxt[j] = (hx <<< (2*HW)) + (mx <<< HW) + lx;
    end
  end

  always_comb begin
    logic signed [DW-1:0] d1, d2, d3, d6;
    d1 = d_r[6][0];
    d2 = d_r[6][1];
    d3 = d_r[6][2];
    d6 = d_r[6][5];
    item_nxt.region = stcp_pkg::RG_IN;
    item_nxt.base   = geo_r[6].p0;
    item_nxt.dir1   = geo_r[6].e01;
    item_nxt.dir2   = geo_r[6].e02;
    item_nxt.num1   = vb_r;
    item_nxt.num2   = vc_r;
    item_nxt.den    = va_r + vb_r + vc_r;
    if (d1 <= 0 && d2 <= 0) begin
      item_nxt.region = stcp_pkg::RG_V0;
      item_nxt.num1   = '0;
      item_nxt.num2   = '0;
      item_nxt.den    = '0;
    end else if (d3 >= 0 && n_r <= 0) begin
      item_nxt.region = stcp_pkg::RG_V1;
      item_nxt.base   = geo_r[6].p1;
      item_nxt.num1   = '0;
      item_nxt.num2   = '0;
      item_nxt.den    = '0;
    end else if (vc_r <= 0 && d1 >= 0 && d3 <= 0) begin
      item_nxt.region = stcp_pkg::RG_E01;
      item_nxt.num1   = VW'(d1);
      item_nxt.num2   = '0;
      item_nxt.den    = VW'(d1) - VW'(d3);
    end else if (d6 >= 0 && m_r <= 0) begin
      item_nxt.region = stcp_pkg::RG_V2;
      item_nxt.base   = geo_r[6].p2;
      item_nxt.num1   = '0;
      item_nxt.num2   = '0;
      item_nxt.den    = '0;
    end else if (vb_r <= 0 && d2 >= 0 && d6 <= 0) begin
      item_nxt.region = stcp_pkg::RG_E02;
      item_nxt.dir1   = geo_r[6].e02;
      item_nxt.num1   = VW'(d2);
      item_nxt.num2   = '0;
      item_nxt.den    = VW'(d2) - VW'(d6);
    end else if (va_r <= 0 && n_r >= 0 && m_r >= 0) begin
      item_nxt.region = stcp_pkg::RG_E12;
      item_nxt.base   = geo_r[6].p1;
      item_nxt.dir1   = geo_r[6].e12;
      item_nxt.num1   = VW'(n_r);
      item_nxt.num2   = '0;
      item_nxt.den    = VW'(n_r) + VW'(m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[1] <= geo_in;
      for (int s = 2; s <= 6; s++) begin
        geo_r[s] <= geo_r[s-1];
      end
      a_r    <= a_in;
      pr_r   <= pr_nxt;
      d_r[3] <= d_nxt;
      d_r[4] <= d_r[3];
      d_r[5] <= d_r[4];
      d_r[6] <= d_r[5];
      hh_r   <= hh_nxt;
      mid_r  <= mid_nxt;
      ll_r   <= ll_nxt;
      pm_r   <= pm_nxt;
      vc_r   <= VW'(pm_r[0]) - VW'(pm_r[1]);
      vb_r   <= VW'(pm_r[2]) - VW'(pm_r[3]);
      va_r   <= VW'(pm_r[4]) - VW'(pm_r[5]);
      n_r    <= (DW+1)'(d_r[5][3]) - (DW+1)'(d_r[5][2]);
      m_r    <= (DW+1)'(d_r[5][4]) - (DW+1)'(d_r[5][5]);
      item_r <= item_nxt;
    end
  end

endmodule

### sv/stcp_back.sv
// Back end: pipelined fraction dividers, interpolation, saturation and the hit test.
module stcp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  stcp_pkg::qi_t                q_item,
  output logic                         q_pop,
  input  stcp_pkg::pt_t                cen,
  input  logic [stcp_pkg::RW-1:0]      rad,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stcp_pkg::OUT_W-1:0]   out_data
);

  localparam int TB  = stcp_pkg::TB;
  localparam int VW  = stcp_pkg::VW;
  localparam int DW  = stcp_pkg::DW;
  localparam int PRW = stcp_pkg::PRW;
  localparam int CW  = stcp_pkg::CW;
  localparam int RW  = stcp_pkg::RW;
  localparam int DFW = stcp_pkg::DFW;
  localparam int NS  = TB + 5;
  localparam int PXW = TB + 2 + DFW;
  localparam int PTW = PXW - TB;
  localparam int SW  = PTW + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic                    en;
  logic [NS-1:0]           vld_r;
  stcp_pkg::pay_t          pay_r [0:TB+1];
  logic [VW-1:0]           rem_r [0:TB][2];
  logic [VW-1:0]           den_r [0:TB][2];
  logic [TB-1:0]           q_r   [0:TB][2];
  logic                    one_r [0:TB][2];
  logic [VW-1:0]           rem_nxt [1:TB][2];
  logic [TB-1:0]           qb_nxt  [1:TB][2];
  logic [VW-1:0]           rem0_nxt [2];
  logic [VW-1:0]           den0_nxt [2];
  logic                    one0_nxt [2];
  logic signed [PXW-1:0]   px_nxt [2][3];
  logic signed [PXW-1:0]   px_r   [2][3];
  stcp_pkg::pt_t           near_nxt;
  stcp_pkg::dl_t           dv_nxt;
  stcp_pkg::pt_t           near18_r, near19_r;
  stcp_pkg::dl_t           dv_r;
  logic [2:0]              rg18_r, rg19_r;
  logic [PRW-1:0]          sq_r [3];
  logic [2*RW-1:0]         r2_r;
  logic [DW-1:0]           dist_sum;
  logic [stcp_pkg::OUT_W-1:0] out_data_r;

  assign en        = !vld_r[NS-1] || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid = vld_r[NS-1];
  assign out_data  = out_data_r;

  // A weight is zero for a non-positive numerator or divisor and one when
  // the numerator reaches the divisor; only the rest go through the divider.
  always_comb begin
    logic signed [VW-1:0] num;
    logic                 zero;
    for (int f = 0; f < 2; f++) begin
      num          = (f == 0) ? q_item.num1 : q_item.num2;
      zero         = (q_item.den <= 0) || (num <= 0);
      one0_nxt[f]  = !zero && (num >= q_item.den);
      rem0_nxt[f]  = (zero || one0_nxt[f]) ? '0 : num;
      den0_nxt[f]  = (zero || one0_nxt[f]) ? '1 : q_item.den;
    end
  end

  // One restoring division step per stage.
  always_comb begin
    logic [VW-1:0] r2;
    logic          ge;
    for (int s = 1; s <= TB; s++) begin
      for (int f = 0; f < 2; f++) begin
        r2            = {rem_r[s-1][f][VW-2:0], 1'b0};
        ge            = (r2 >= den_r[s-1][f]);
        rem_nxt[s][f] = ge ? (r2 - den_r[s-1][f]) : r2;
        qb_nxt[s][f]  = {q_r[s-1][f][TB-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [TB:0] t;
    for (int f = 0; f < 2; f++) begin
      t = one_r[TB][f] ? ((TB+1)'(1) << TB) : {1'b0, q_r[TB][f]};
      for (int k = 0; k < 3; k++) begin
        px_nxt[f][k] = $signed({1'b0, t})
                     * $signed((f == 0) ? pay_r[TB].dir1[k] : pay_r[TB].dir2[k]);
      end
    end
  end

  // Offsets are truncated toward zero, then the sum saturates to a coordinate.
  always_comb begin
    logic signed [PXW-1:0] adj;
    logic signed [PTW-1:0] part [2];
    logic signed [SW-1:0]  sum;
    for (int k = 0; k < 3; k++) begin
      for (int f = 0; f < 2; f++) begin
        adj     = px_r[f][k][PXW-1] ? (px_r[f][k] + PXW'((64'sd1 <<< TB) - 64'sd1))
                                    : px_r[f][k];
        part[f] = adj[PXW-1:TB];
      end
      sum = SW'($signed(pay_r[TB+1].base[k])) + SW'(part[0]) + SW'(part[1]);
      if (sum > SMAX) begin
        near_nxt[k] = SMAX[CW-1:0];
      end else if (sum < SMIN) begin
        near_nxt[k] = SMIN[CW-1:0];
      end else begin
        near_nxt[k] = sum[CW-1:0];
      end
      dv_nxt[k] = stcp_pkg::dif(near_nxt[k], cen[k]);
    end
  end

  assign dist_sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0].region <= q_item.region;
      pay_r[0].base   <= q_item.base;
      pay_r[0].dir1   <= q_item.dir1;
      pay_r[0].dir2   <= q_item.dir2;
      for (int f = 0; f < 2; f++) begin
        rem_r[0][f] <= rem0_nxt[f];
        den_r[0][f] <= den0_nxt[f];
        one_r[0][f] <= one0_nxt[f];
        q_r[0][f]   <= '0;
      end
      for (int s = 1; s <= TB; s++) begin
        pay_r[s] <= pay_r[s-1];
        for (int f = 0; f < 2; f++) begin
          rem_r[s][f] <= rem_nxt[s][f];
          den_r[s][f] <= den_r[s-1][f];
          one_r[s][f] <= one_r[s-1][f];
          q_r[s][f]   <= qb_nxt[s][f];
        end
      end
      pay_r[TB+1] <= pay_r[TB];
      px_r        <= px_nxt;
      near18_r    <= near_nxt;
      dv_r        <= dv_nxt;
      rg18_r      <= pay_r[TB+1].region;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= PRW'($signed(dv_r[k]) * $signed(dv_r[k]));
      end
      r2_r       <= rad * rad;
      near19_r   <= near18_r;
      rg19_r     <= rg18_r;
      out_data_r <= {{(stcp_pkg::OUT_W - stcp_pkg::OUT_BITS){1'b0}}, rg19_r, near19_r,
                     (dist_sum <= DW'(r2_r))};
    end
  end

endmodule
